// ===== hw/rtl/cic_pkg.sv =====
package cic_pkg;

    // Duplicate-filter table depth and its pointer width
    localparam int SEEN_DEPTH = 16;
    localparam int SEEN_PTR_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int KEY_W      = 64;

    // Configuration register indexes
    localparam logic [1:0] CFG_RETRY_BUDGET = 2'd0;
    localparam logic [1:0] CFG_ZONE_X       = 2'd1;
    localparam logic [1:0] CFG_ZONE_Y       = 2'd2;

    localparam logic [3:0] RETRY_BUDGET_RST = 4'd2;

    // Command / reply opcodes
    localparam logic [2:0] OP_BOOT    = 3'd0;
    localparam logic [2:0] OP_ARM     = 3'd1;
    localparam logic [2:0] OP_FIRE    = 3'd2;
    localparam logic [2:0] OP_CONFIRM = 3'd3;
    localparam logic [2:0] OP_REFRESH = 3'd4;
    localparam logic [2:0] OP_RECOVER = 3'd5;
    localparam logic [2:0] OP_HALT    = 3'd6;

    // Reply classes
    localparam logic [1:0] CLS_ACK    = 2'd0;
    localparam logic [1:0] CLS_NACK   = 2'd1;
    localparam logic [1:0] CLS_STATUS = 2'd2;
    localparam logic [1:0] CLS_ERROR  = 2'd3;

    // Zone modes
    localparam logic [2:0] MODE_RESET      = 3'd0;
    localparam logic [2:0] MODE_IDLE       = 3'd1;
    localparam logic [2:0] MODE_ARMED      = 3'd2;
    localparam logic [2:0] MODE_RECOVERING = 3'd3;
    localparam logic [2:0] MODE_HALTED     = 3'd4;

    // Reason codes
    localparam logic [4:0] RSN_ZONE_HALTED    = 5'd0;
    localparam logic [4:0] RSN_INVALID_PACKET = 5'd1;
    localparam logic [4:0] RSN_DUPLICATE      = 5'd2;
    localparam logic [4:0] RSN_CONFIRM_LOCAL  = 5'd3;
    localparam logic [4:0] RSN_ALREADY_BOOTED = 5'd4;
    localparam logic [4:0] RSN_BOOT_COMMITTED = 5'd5;
    localparam logic [4:0] RSN_NOT_IDLE       = 5'd6;
    localparam logic [4:0] RSN_RES_RESERVED   = 5'd7;
    localparam logic [4:0] RSN_NOT_ARMED      = 5'd8;
    localparam logic [4:0] RSN_ACT_NOT_ACC    = 5'd9;
    localparam logic [4:0] RSN_COMMIT_CONF    = 5'd10;
    localparam logic [4:0] RSN_RETRY_REQ      = 5'd11;
    localparam logic [4:0] RSN_UNBOOTED       = 5'd12;
    localparam logic [4:0] RSN_NO_VALID_SRC   = 5'd13;
    localparam logic [4:0] RSN_SCRUB_COMMIT   = 5'd14;
    localparam logic [4:0] RSN_RECOVERY_DONE  = 5'd15;
    localparam logic [4:0] RSN_REMOTE_HALT    = 5'd16;
    localparam logic [4:0] RSN_BUDGET_EXHAUST = 5'd17;
    localparam logic [4:0] RSN_WRONG_ENDPOINT = 5'd18;

    localparam logic [15:0] COMMIT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  src_x;
        logic [7:0]  src_y;
        logic [7:0]  dst_x;
        logic [7:0]  dst_y;
        logic [31:0] txn_id;
        logic [3:0]  try_number;
        logic [15:0] seq_no;
        logic        integrity_ok;
        logic        refresh_source_ok;
        logic        act_accepted;
        logic        act_confirmed;
    } cic_in_t;

    typedef struct packed {
        logic [1:0]  reply_class;
        logic [2:0]  reply_op;
        logic [4:0]  reason;
        logic [7:0]  reply_dst_x;
        logic [7:0]  reply_dst_y;
        logic [31:0] reply_txn;
        logic [3:0]  reply_try;
        logic [15:0] reply_seq;
        logic        fire_pulse;
        logic        reset_pulse;
        logic [2:0]  zone_mode;
        logic [15:0] commit_total;
    } cic_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic load_match;
        logic execute;
    } cic_cmd_t;

endpackage

// ===== hw/rtl/cic_seen.sv =====
module cic_seen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cic_pkg::KEY_W-1:0]      key,
    input  logic                           load_match,
    input  logic                           record,
    output logic                           dup
);

    logic [cic_pkg::KEY_W-1:0]      keys_reg [cic_pkg::SEEN_DEPTH];
    logic [cic_pkg::SEEN_DEPTH-1:0] valid_reg;
    logic [cic_pkg::SEEN_PTR_W-1:0] ptr_reg;
    logic [cic_pkg::SEEN_PTR_W-1:0] ptr_next;
    logic [cic_pkg::SEEN_DEPTH-1:0] match_reg;
    logic [cic_pkg::SEEN_DEPTH-1:0] match_next;

    always_comb begin
        for (int i = 0; i < cic_pkg::SEEN_DEPTH; i++) begin
            match_next[i] = valid_reg[i] && (keys_reg[i] == key);
        end
    end

    // Oldest entry is replaced first
    assign ptr_next = (ptr_reg == cic_pkg::SEEN_PTR_W'(cic_pkg::SEEN_DEPTH - 1))
                      ? '0 : ptr_reg + 1'b1;

    assign dup = |match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else if (record) begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (record) begin
            keys_reg[ptr_reg] <= key;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_match) begin
            match_reg <= match_next;
        end
    end

endmodule

// ===== hw/rtl/cic_dp.sv =====
module cic_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  cic_pkg::cic_cmd_t  cmd,
    input  cic_pkg::cic_in_t   s_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    output cic_pkg::cic_out_t  m_data
);

    cic_pkg::cic_in_t  item_reg;
    cic_pkg::cic_out_t result_reg;
    cic_pkg::cic_out_t result_next;

    logic [3:0]  retry_budget_reg;
    logic [7:0]  zone_x_reg;
    logic [7:0]  zone_y_reg;

    logic [2:0]  mode_reg,   mode_next;
    logic        booted_reg, booted_next;
    logic [31:0] armed_txn_reg, armed_txn_next;
    logic [15:0] commit_reg, commit_next;

    logic [cic_pkg::KEY_W-1:0] key;
    logic dup;
    logic record;

    assign key = {item_reg.src_x, item_reg.src_y, item_reg.txn_id, item_reg.seq_no};

    cic_seen u_seen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key        (key),
        .load_match (cmd.load_match),
        .record     (record),
        .dup        (dup)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_budget_reg <= cic_pkg::RETRY_BUDGET_RST;
            zone_x_reg       <= '0;
            zone_y_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cic_pkg::CFG_RETRY_BUDGET: retry_budget_reg <= cfg_wdata[3:0];
                cic_pkg::CFG_ZONE_X:       zone_x_reg       <= cfg_wdata;
                cic_pkg::CFG_ZONE_Y:       zone_y_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic rec;
        rec            = 1'b0;
        mode_next      = mode_reg;
        booted_next    = booted_reg;
        armed_txn_next = armed_txn_reg;
        commit_next    = commit_reg;

        result_next.reply_class  = cic_pkg::CLS_NACK;
        result_next.reply_op     = item_reg.command;
        result_next.reason       = cic_pkg::RSN_ZONE_HALTED;
        result_next.reply_dst_x  = item_reg.src_x;
        result_next.reply_dst_y  = item_reg.src_y;
        result_next.reply_txn    = item_reg.txn_id;
        result_next.reply_try    = item_reg.try_number;
        result_next.reply_seq    = item_reg.seq_no;
        result_next.fire_pulse   = 1'b0;
        result_next.reset_pulse  = 1'b0;

        if (mode_reg == cic_pkg::MODE_HALTED && item_reg.command != cic_pkg::OP_BOOT) begin
            result_next.reply_op = cic_pkg::OP_HALT;
        end else if (!item_reg.integrity_ok) begin
            mode_next               = cic_pkg::MODE_RECOVERING;
            result_next.reset_pulse = 1'b1;
            result_next.reply_op    = cic_pkg::OP_RECOVER;
            result_next.reason      = cic_pkg::RSN_INVALID_PACKET;
        end else if (item_reg.dst_x != zone_x_reg || item_reg.dst_y != zone_y_reg) begin
            result_next.reply_class = cic_pkg::CLS_ERROR;
            result_next.reason      = cic_pkg::RSN_WRONG_ENDPOINT;
        end else if (dup) begin
            result_next.reply_class = cic_pkg::CLS_ACK;
            result_next.reason      = cic_pkg::RSN_DUPLICATE;
        end else begin
            rec = 1'b1;
            case (item_reg.command)
                cic_pkg::OP_BOOT: begin
                    if (mode_reg != cic_pkg::MODE_RESET && mode_reg != cic_pkg::MODE_HALTED) begin
                        result_next.reason = cic_pkg::RSN_ALREADY_BOOTED;
                    end else begin
                        booted_next             = 1'b1;
                        mode_next               = cic_pkg::MODE_IDLE;
                        result_next.reply_class = cic_pkg::CLS_ACK;
                        result_next.reason      = cic_pkg::RSN_BOOT_COMMITTED;
                    end
                end
                cic_pkg::OP_ARM: begin
                    if (!booted_reg || mode_reg != cic_pkg::MODE_IDLE) begin
                        result_next.reason = cic_pkg::RSN_NOT_IDLE;
                    end else begin
                        armed_txn_next          = item_reg.txn_id;
                        mode_next               = cic_pkg::MODE_ARMED;
                        result_next.reply_class = cic_pkg::CLS_ACK;
                        result_next.reason      = cic_pkg::RSN_RES_RESERVED;
                    end
                end
                cic_pkg::OP_FIRE: begin
                    if (!booted_reg || mode_reg != cic_pkg::MODE_ARMED ||
                        armed_txn_reg != item_reg.txn_id) begin
                        result_next.reason = cic_pkg::RSN_NOT_ARMED;
                    end else begin
                        result_next.fire_pulse = 1'b1;
                        if (!item_reg.act_accepted) begin
                            result_next.reset_pulse = 1'b1;
                            mode_next               = cic_pkg::MODE_IDLE;
                            result_next.reason      = cic_pkg::RSN_ACT_NOT_ACC;
                        end else if (item_reg.act_confirmed) begin
                            if (commit_reg != cic_pkg::COMMIT_MAX) begin
                                commit_next = commit_reg + 16'd1;
                            end
                            mode_next               = cic_pkg::MODE_IDLE;
                            result_next.reply_class = cic_pkg::CLS_STATUS;
                            result_next.reply_op    = cic_pkg::OP_CONFIRM;
                            result_next.reason      = cic_pkg::RSN_COMMIT_CONF;
                        end else begin
                            result_next.reset_pulse = 1'b1;
                            if (item_reg.try_number < retry_budget_reg) begin
                                mode_next            = cic_pkg::MODE_IDLE;
                                result_next.reply_op = cic_pkg::OP_RECOVER;
                                result_next.reason   = cic_pkg::RSN_RETRY_REQ;
                            end else begin
                                mode_next            = cic_pkg::MODE_HALTED;
                                result_next.reply_op = cic_pkg::OP_HALT;
                                result_next.reason   = cic_pkg::RSN_BUDGET_EXHAUST;
                            end
                        end
                    end
                end
                cic_pkg::OP_REFRESH: begin
                    if (!booted_reg) begin
                        result_next.reason = cic_pkg::RSN_UNBOOTED;
                    end else if (!item_reg.refresh_source_ok) begin
                        result_next.reason = cic_pkg::RSN_NO_VALID_SRC;
                    end else begin
                        result_next.reply_class = cic_pkg::CLS_ACK;
                        result_next.reason      = cic_pkg::RSN_SCRUB_COMMIT;
                    end
                end
                cic_pkg::OP_RECOVER: begin
                    if (!booted_reg) begin
                        result_next.reason = cic_pkg::RSN_UNBOOTED;
                    end else begin
                        result_next.reset_pulse = 1'b1;
                        mode_next               = cic_pkg::MODE_IDLE;
                        result_next.reply_class = cic_pkg::CLS_ACK;
                        result_next.reason      = cic_pkg::RSN_RECOVERY_DONE;
                    end
                end
                cic_pkg::OP_HALT: begin
                    result_next.reset_pulse = 1'b1;
                    mode_next               = cic_pkg::MODE_HALTED;
                    result_next.reason      = cic_pkg::RSN_REMOTE_HALT;
                end
                default: begin
                    // confirm and the unused code are rejected alike
                    result_next.reply_op = cic_pkg::OP_CONFIRM;
                    result_next.reason   = cic_pkg::RSN_CONFIRM_LOCAL;
                end
            endcase
        end

        result_next.zone_mode    = mode_next;
        result_next.commit_total = commit_next;
        record = rec && cmd.execute;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= cic_pkg::MODE_RESET;
            booted_reg    <= 1'b0;
            armed_txn_reg <= '0;
            commit_reg    <= '0;
        end else if (cmd.execute) begin
            mode_reg      <= mode_next;
            booted_reg    <= booted_next;
            armed_txn_reg <= armed_txn_next;
            commit_reg    <= commit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.execute) begin
            result_reg <= result_next;
        end
    end

    assign m_data = result_reg;

endmodule

// ===== hw/rtl/cic_ctrl.sv =====
module cic_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output cic_pkg::cic_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.load_match = 1'b0;
        cmd.execute    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.load_match = 1'b1;
                state_next     = ST_EXEC;
            end
            ST_EXEC: begin
                // hold the decision until the output register is free
                if (out_free) begin
                    cmd.execute = 1'b1;
                    s_ready     = 1'b1;
                    state_next  = s_valid ? ST_MATCH : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.load_item = s_valid && s_ready;
        m_valid_next  = cmd.execute ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/command_interlock_controller.sv =====
// Zone command interlock controller: one reply for every command packet, in
// order. A packet is captured into the item register, compared against all 16
// entries of the recent-key table at once into a registered match vector, and
// then decided and written to the output register, during which the next
// packet can already be taken. A result that is not taken stalls the decision
// until the output register frees. No clearing pass follows reset. Configuration
// writes (retry budget, zone x, zone y) are taken any cycle and should be made
// while no packet is pending.
module command_interlock_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cic_pkg::cic_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cic_pkg::cic_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata
);

    cic_pkg::cic_cmd_t ctl_cmd;

    cic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (ctl_cmd)
    );

    cic_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (ctl_cmd),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.execute |-> (!m_valid || m_ready))
        else $error("result overwritten before transfer");

    a_wrong_ep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reply_class == cic_pkg::CLS_ERROR
        |-> m_data.reason == cic_pkg::RSN_WRONG_ENDPOINT)
        else $error("error class without wrong endpoint reason");

    a_fire_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fire_pulse
        |-> m_data.reset_pulse || m_data.reply_class == cic_pkg::CLS_STATUS)
        else $error("fire without confirm or actuator reset");

endmodule

// ===== sim/command_interlock_controller_test.sv =====
`timescale 1ns / 100ps

module command_interlock_controller_test;

    localparam logic [2:0] OP_SPARE    = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         RECENT_KEEP = 24;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    cic_pkg::cic_in_t  s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    cic_pkg::cic_out_t m_data;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = cic_pkg::CFG_RETRY_BUDGET;
    logic [7:0]        cfg_wdata = '0;

    command_interlock_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Zone state as the predictor sees it
    logic [3:0]                     cfg_budget  = cic_pkg::RETRY_BUDGET_RST;
    logic [7:0]                     cfg_zone_x  = '0;
    logic [7:0]                     cfg_zone_y  = '0;
    logic [2:0]                     zone_state  = cic_pkg::MODE_RESET;
    logic                           zone_booted = 1'b0;
    logic [31:0]                    armed_id    = '0;
    logic [15:0]                    commits     = '0;
    logic [cic_pkg::KEY_W-1:0]      seen_keys [cic_pkg::SEEN_DEPTH];
    logic [cic_pkg::SEEN_DEPTH-1:0] seen_valid  = '0;
    logic [cic_pkg::SEEN_PTR_W-1:0] seen_ptr    = '0;

    cic_pkg::cic_in_t  pending_pkts [$];
    cic_pkg::cic_in_t  recent_pkts [$];
    cic_pkg::cic_out_t reply_queue [$];
    cic_pkg::cic_out_t want_reply;

    int send_idle_pct  = 27;
    int recv_idle_pct  = 58;
    int queued_total   = 0;
    int packets_sent   = 0;
    int replies_seen   = 0;
    int mismatches     = 0;
    int dup_hits       = 0;
    int commit_events  = 0;
    int halt_events    = 0;
    int stall_cycles   = 0;
    logic [3:0] last_budget;

    function automatic cic_pkg::cic_out_t zone_reply(cic_pkg::cic_in_t p);
        cic_pkg::cic_out_t         r;
        logic [cic_pkg::KEY_W-1:0] key;
        logic                      dup;
        int                        i;
        r             = '0;
        r.reply_class = cic_pkg::CLS_NACK;
        r.reply_op    = p.command;
        r.reason      = cic_pkg::RSN_ZONE_HALTED;
        r.reply_dst_x = p.src_x;
        r.reply_dst_y = p.src_y;
        r.reply_txn   = p.txn_id;
        r.reply_try   = p.try_number;
        r.reply_seq   = p.seq_no;
        dup           = 1'b0;
        if (zone_state == cic_pkg::MODE_HALTED && p.command != cic_pkg::OP_BOOT) begin
            r.reply_op = cic_pkg::OP_HALT;
        end else if (!p.integrity_ok) begin
            zone_state    = cic_pkg::MODE_RECOVERING;
            r.reset_pulse = 1'b1;
            r.reply_op    = cic_pkg::OP_RECOVER;
            r.reason      = cic_pkg::RSN_INVALID_PACKET;
        end else if (p.dst_x != cfg_zone_x || p.dst_y != cfg_zone_y) begin
            r.reply_class = cic_pkg::CLS_ERROR;
            r.reason      = cic_pkg::RSN_WRONG_ENDPOINT;
        end else begin
            key = {p.src_x, p.src_y, p.txn_id, p.seq_no};
            for (i = 0; i < cic_pkg::SEEN_DEPTH; i++)
                if (seen_valid[i] && seen_keys[i] == key) dup = 1'b1;
            if (dup) begin
                r.reply_class = cic_pkg::CLS_ACK;
                r.reason      = cic_pkg::RSN_DUPLICATE;
                dup_hits++;
            end else begin
                seen_keys[seen_ptr]  = key;
                seen_valid[seen_ptr] = 1'b1;
                seen_ptr             = seen_ptr + 1'b1;
                case (p.command)
                    cic_pkg::OP_BOOT: begin
                        if (zone_state != cic_pkg::MODE_RESET &&
                            zone_state != cic_pkg::MODE_HALTED) begin
                            r.reason = cic_pkg::RSN_ALREADY_BOOTED;
                        end else begin
                            zone_booted   = 1'b1;
                            zone_state    = cic_pkg::MODE_IDLE;
                            r.reply_class = cic_pkg::CLS_ACK;
                            r.reason      = cic_pkg::RSN_BOOT_COMMITTED;
                        end
                    end
                    cic_pkg::OP_ARM: begin
                        if (!zone_booted || zone_state != cic_pkg::MODE_IDLE) begin
                            r.reason = cic_pkg::RSN_NOT_IDLE;
                        end else begin
                            armed_id      = p.txn_id;
                            zone_state    = cic_pkg::MODE_ARMED;
                            r.reply_class = cic_pkg::CLS_ACK;
                            r.reason      = cic_pkg::RSN_RES_RESERVED;
                        end
                    end
                    cic_pkg::OP_FIRE: begin
                        if (!zone_booted || zone_state != cic_pkg::MODE_ARMED ||
                            armed_id != p.txn_id) begin
                            r.reason = cic_pkg::RSN_NOT_ARMED;
                        end else begin
                            r.fire_pulse = 1'b1;
                            if (!p.act_accepted) begin
                                r.reset_pulse = 1'b1;
                                zone_state    = cic_pkg::MODE_IDLE;
                                r.reason      = cic_pkg::RSN_ACT_NOT_ACC;
                            end else if (p.act_confirmed) begin
                                if (commits != cic_pkg::COMMIT_MAX) commits = commits + 1'b1;
                                commit_events++;
                                zone_state    = cic_pkg::MODE_IDLE;
                                r.reply_class = cic_pkg::CLS_STATUS;
                                r.reply_op    = cic_pkg::OP_CONFIRM;
                                r.reason      = cic_pkg::RSN_COMMIT_CONF;
                            end else begin
                                r.reset_pulse = 1'b1;
                                if (p.try_number < cfg_budget) begin
                                    zone_state = cic_pkg::MODE_IDLE;
                                    r.reply_op = cic_pkg::OP_RECOVER;
                                    r.reason   = cic_pkg::RSN_RETRY_REQ;
                                end else begin
                                    zone_state = cic_pkg::MODE_HALTED;
                                    r.reply_op = cic_pkg::OP_HALT;
                                    r.reason   = cic_pkg::RSN_BUDGET_EXHAUST;
                                    halt_events++;
                                end
                            end
                        end
                    end
                    cic_pkg::OP_REFRESH: begin
                        if (!zone_booted) begin
                            r.reason = cic_pkg::RSN_UNBOOTED;
                        end else if (!p.refresh_source_ok) begin
                            r.reason = cic_pkg::RSN_NO_VALID_SRC;
                        end else begin
                            r.reply_class = cic_pkg::CLS_ACK;
                            r.reason      = cic_pkg::RSN_SCRUB_COMMIT;
                        end
                    end
                    cic_pkg::OP_RECOVER: begin
                        if (!zone_booted) begin
                            r.reason = cic_pkg::RSN_UNBOOTED;
                        end else begin
                            r.reset_pulse = 1'b1;
                            zone_state    = cic_pkg::MODE_IDLE;
                            r.reply_class = cic_pkg::CLS_ACK;
                            r.reason      = cic_pkg::RSN_RECOVERY_DONE;
                        end
                    end
                    cic_pkg::OP_HALT: begin
                        r.reset_pulse = 1'b1;
                        zone_state    = cic_pkg::MODE_HALTED;
                        r.reason      = cic_pkg::RSN_REMOTE_HALT;
                        halt_events++;
                    end
                    default: begin
                        // confirm and the spare code are local-only
                        r.reply_op = cic_pkg::OP_CONFIRM;
                        r.reason   = cic_pkg::RSN_CONFIRM_LOCAL;
                    end
                endcase
            end
        end
        r.zone_mode    = zone_state;
        r.commit_total = commits;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40) $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("reply %0d %s: got %0h, expected %0h",
                                      replies_seen, name, got, want));
    endtask

    // Driver: hold the packet until the transfer, then predict its reply
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                reply_queue.insert(reply_queue.size(), zone_reply(s_data));
                packets_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_pkts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_pkts[0];
                    pending_pkts.delete(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each reply transfer with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_queue.size() == 0) begin
                    report_mismatch("reply with no command outstanding");
                end else begin
                    want_reply = reply_queue[0];
                    reply_queue.delete(0);
                    check_field("reply_class", 32'(m_data.reply_class),
                                32'(want_reply.reply_class));
                    check_field("reply_op", 32'(m_data.reply_op), 32'(want_reply.reply_op));
                    check_field("reason", 32'(m_data.reason), 32'(want_reply.reason));
                    check_field("reply_dst_x", 32'(m_data.reply_dst_x),
                                32'(want_reply.reply_dst_x));
                    check_field("reply_dst_y", 32'(m_data.reply_dst_y),
                                32'(want_reply.reply_dst_y));
                    check_field("reply_txn", m_data.reply_txn, want_reply.reply_txn);
                    check_field("reply_try", 32'(m_data.reply_try), 32'(want_reply.reply_try));
                    check_field("reply_seq", 32'(m_data.reply_seq), 32'(want_reply.reply_seq));
                    check_field("fire_pulse", 32'(m_data.fire_pulse),
                                32'(want_reply.fire_pulse));
                    check_field("reset_pulse", 32'(m_data.reset_pulse),
                                32'(want_reply.reset_pulse));
                    check_field("zone_mode", 32'(m_data.zone_mode), 32'(want_reply.zone_mode));
                    check_field("commit_total", 32'(m_data.commit_total),
                                32'(want_reply.commit_total));
                end
                replies_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cic_pkg::CFG_RETRY_BUDGET: cfg_budget = val[3:0];
            cic_pkg::CFG_ZONE_X:       cfg_zone_x = val;
            cic_pkg::CFG_ZONE_Y:       cfg_zone_y = val;
            default:                   ;
        endcase
    endtask

    task automatic apply_settings(logic [3:0] budget, logic [7:0] zx, logic [7:0] zy);
        // upper nibble of the budget write is junk the register must drop
        write_reg(cic_pkg::CFG_RETRY_BUDGET, {4'($urandom_range(15)), budget});
        write_reg(cic_pkg::CFG_ZONE_X, zx);
        write_reg(cic_pkg::CFG_ZONE_Y, zy);
        last_budget = budget;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_pkts.size() != 0 || s_valid || reply_queue.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic cic_pkg::cic_in_t fresh_pkt(logic [2:0] cmd, logic [31:0] txn);
        cic_pkg::cic_in_t p;
        p.command           = cmd;
        p.src_x             = 8'($urandom_range(255));
        p.src_y             = 8'($urandom_range(255));
        p.dst_x             = cfg_zone_x;
        p.dst_y             = cfg_zone_y;
        p.txn_id            = txn;
        p.try_number        = 4'($urandom_range(15));
        p.seq_no            = 16'($urandom_range(65535));
        p.integrity_ok      = 1'b1;
        p.refresh_source_ok = 1'($urandom_range(1));
        p.act_accepted      = 1'($urandom_range(1));
        p.act_confirmed     = 1'($urandom_range(1));
        return p;
    endfunction

    task automatic queue_pkt(cic_pkg::cic_in_t p);
        pending_pkts.insert(pending_pkts.size(), p);
        recent_pkts.insert(recent_pkts.size(), p);
        if (recent_pkts.size() > RECENT_KEEP) recent_pkts.delete(0);
        queued_total++;
    endtask

    task automatic queue_scenario();
        cic_pkg::cic_in_t p;
        logic [95:0]      raw;
        logic [31:0]      txn;
        int               pick;
        pick = $urandom_range(99);
        txn  = $urandom;
        if (pick < 40) begin
            // arm then fire, sometimes after a boot or recover
            if ($urandom_range(3) == 0) queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, $urandom));
            else if ($urandom_range(2) == 0) queue_pkt(fresh_pkt(cic_pkg::OP_RECOVER, $urandom));
            queue_pkt(fresh_pkt(cic_pkg::OP_ARM, txn));
            p = fresh_pkt(cic_pkg::OP_FIRE, ($urandom_range(9) == 0) ? $urandom : txn);
            p.act_accepted = ($urandom_range(4) != 0);
            queue_pkt(p);
        end else if (pick < 48) begin
            queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, txn));
        end else if (pick < 56) begin
            queue_pkt(fresh_pkt(cic_pkg::OP_REFRESH, txn));
        end else if (pick < 61) begin
            queue_pkt(fresh_pkt(cic_pkg::OP_RECOVER, txn));
        end else if (pick < 66) begin
            queue_pkt(fresh_pkt(cic_pkg::OP_HALT, txn));
            if ($urandom_range(3) != 0) queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, $urandom));
        end else if (pick < 71) begin
            queue_pkt(fresh_pkt($urandom_range(1) ? cic_pkg::OP_CONFIRM : OP_SPARE, txn));
        end else if (pick < 81 && recent_pkts.size() != 0) begin
            // replay a recent key, possibly already out of the table
            p = recent_pkts[$urandom_range(recent_pkts.size() - 1)];
            p.command       = 3'($urandom_range(7));
            p.dst_x         = cfg_zone_x;
            p.dst_y         = cfg_zone_y;
            p.integrity_ok  = 1'b1;
            p.act_accepted  = 1'($urandom_range(1));
            p.act_confirmed = 1'($urandom_range(1));
            queue_pkt(p);
        end else if (pick < 87) begin
            p = fresh_pkt(3'($urandom_range(7)), txn);
            case ($urandom_range(2))
                0: p.dst_x = cfg_zone_x ^ 8'($urandom_range(1, 255));
                1: p.dst_y = cfg_zone_y ^ 8'($urandom_range(1, 255));
                default: begin
                    p.dst_x = cfg_zone_x ^ 8'($urandom_range(1, 255));
                    p.dst_y = cfg_zone_y ^ 8'($urandom_range(1, 255));
                end
            endcase
            queue_pkt(p);
        end else if (pick < 93) begin
            p = fresh_pkt(3'($urandom_range(7)), txn);
            p.integrity_ok = 1'b0;
            queue_pkt(p);
        end else begin
            raw = {$urandom, $urandom, $urandom};
            p   = raw[$bits(cic_pkg::cic_in_t)-1:0];
            queue_pkt(p);
        end
    endtask

    task automatic run_directed();
        cic_pkg::cic_in_t p;
        apply_settings(4'd2, 8'hA5, 8'h5A);
        p = fresh_pkt(cic_pkg::OP_ARM, 32'h0);
        p.src_x = 8'h00; p.src_y = 8'h00; p.seq_no = 16'h0000; p.try_number = 4'h0;
        queue_pkt(p);                                           // arm before boot
        queue_pkt(fresh_pkt(cic_pkg::OP_REFRESH, $urandom));     // refresh before boot
        queue_pkt(fresh_pkt(cic_pkg::OP_CONFIRM, $urandom));
        queue_pkt(fresh_pkt(OP_SPARE, $urandom));
        queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, $urandom));
        queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, $urandom));        // second boot refused
        p = fresh_pkt(cic_pkg::OP_REFRESH, $urandom);
        p.dst_x = ~cfg_zone_x;
        queue_pkt(p);                                           // wrong endpoint
        p = fresh_pkt(cic_pkg::OP_REFRESH, $urandom); p.refresh_source_ok = 1'b0; queue_pkt(p);
        p = fresh_pkt(cic_pkg::OP_REFRESH, $urandom); p.refresh_source_ok = 1'b1; queue_pkt(p);
        p = fresh_pkt(cic_pkg::OP_ARM, 32'hFFFF_FFFF);
        p.src_x = 8'hFF; p.src_y = 8'hFF; p.seq_no = 16'hFFFF; p.try_number = 4'hF;
        queue_pkt(p);
        queue_pkt(p);                                           // exact repeat: duplicate
        queue_pkt(fresh_pkt(cic_pkg::OP_FIRE, 32'h1234_5678));   // not the armed transaction
        p = fresh_pkt(cic_pkg::OP_FIRE, 32'hFFFF_FFFF); p.act_accepted = 1'b0; queue_pkt(p);
        queue_pkt(fresh_pkt(cic_pkg::OP_ARM, 32'h0000_0001));
        p = fresh_pkt(cic_pkg::OP_FIRE, 32'h0000_0001);
        p.act_accepted = 1'b1; p.act_confirmed = 1'b1;
        queue_pkt(p);                                           // commit
        queue_pkt(fresh_pkt(cic_pkg::OP_ARM, 32'h0000_0002));
        p = fresh_pkt(cic_pkg::OP_FIRE, 32'h0000_0002);
        p.act_accepted = 1'b1; p.act_confirmed = 1'b0; p.try_number = 4'd1;
        queue_pkt(p);                                           // retry: attempt below budget
        queue_pkt(fresh_pkt(cic_pkg::OP_ARM, 32'h0000_0003));
        p = fresh_pkt(cic_pkg::OP_FIRE, 32'h0000_0003);
        p.act_accepted = 1'b1; p.act_confirmed = 1'b0; p.try_number = 4'd2;
        queue_pkt(p);                                           // budget used up: halt
        p = fresh_pkt(cic_pkg::OP_REFRESH, $urandom); p.integrity_ok = 1'b0;
        queue_pkt(p);                                           // halted wins over integrity
        queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, $urandom));
        p = fresh_pkt(cic_pkg::OP_ARM, $urandom); p.integrity_ok = 1'b0; queue_pkt(p);
        queue_pkt(fresh_pkt(cic_pkg::OP_RECOVER, $urandom));
        queue_pkt(fresh_pkt(cic_pkg::OP_HALT, $urandom));
        queue_pkt(fresh_pkt(cic_pkg::OP_BOOT, $urandom));
        wait_drained();
    endtask

    task automatic run_random(logic [3:0] budget, logic [7:0] zx, logic [7:0] zy, int n);
        int target;
        apply_settings(budget, zx, zy);
        target = queued_total + n;
        while (queued_total < target) queue_scenario();
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 58;
        run_directed();
        run_random(4'd0, 8'h00, 8'h00, 330);

        send_idle_pct = 58;
        recv_idle_pct = 27;
        run_random(4'd15, 8'hFF, 8'hFF, 330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(4'($urandom_range(1, 14)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 340);

        $display("covered %0d command packets over four register settings (last budget %0d),",
                 packets_sent, last_budget);
        $display("%0d replies compared; %0d duplicate hits, %0d commits, %0d halts predicted",
                 replies_seen, dup_hits, commit_events, halt_events);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
